### design/etr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package etr_pkg;

    localparam int PPQN_BITS = 15;
    localparam logic [PPQN_BITS-1:0] PPQN_DEFAULT = 15'd48;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_TICK = 2'd1,
        ST_NOTE = 2'd2
    } status_t;

endpackage

`default_nettype wire

### design/etr_evt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface etr_evt_if #(
    parameter int TICK_BITS = 64,
    parameter int DURATION_BITS = 32
);
    logic                     valid;
    logic                     ready;
    logic [TICK_BITS-1:0]     event_tick;
    logic                     is_note;
    logic [DURATION_BITS-1:0] note_duration;

    modport source (output valid, event_tick, is_note, note_duration, input ready);
    modport sink (input valid, event_tick, is_note, note_duration, output ready);
endinterface

`default_nettype wire

### design/etr_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface etr_res_if #(
    parameter int TICK_BITS = 64,
    parameter int DURATION_BITS = 32
);
    logic                     valid;
    logic                     ready;
    logic [TICK_BITS-1:0]     new_tick;
    logic [DURATION_BITS-1:0] new_duration;
    logic [1:0]               status;

    modport source (output valid, new_tick, new_duration, status, input ready);
    modport sink (input valid, new_tick, new_duration, status, output ready);
endinterface

`default_nettype wire

### design/event_tick_timebase_rescaler.sv
`timescale 1ns / 1ps
`default_nettype none

// Rescales timed events from the source to the target timebase and accepts one
// request per clock while the result port is not stalled. A request passes
// through the input queue, the bit-serial divider for whole beats, the stages
// for the multiplications and sums, the divider that rounds the remainder, and
// the stages that combine, check and register the result. Both dividers are
// pipelined one quotient bit per stage, so the tick and the note end advance
// side by side and throughput stays at one result per cycle unless the output
// stalls. Registers are written over the APB port at byte addresses 0, 8 and 16
// and must only be changed while no request is in flight.

module event_tick_timebase_rescaler #(
    parameter int TICK_BITS = 64,
    parameter int DURATION_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    etr_evt_if.sink          evt,
    etr_res_if.source        res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import etr_pkg::*;

    localparam int W = TICK_BITS;
    localparam int D = DURATION_BITS;
    localparam logic [1:0] CFG_SRC = 2'd0;
    localparam logic [1:0] CFG_TGT = 2'd1;
    localparam logic [1:0] CFG_OFS = 2'd2;

    logic [PPQN_BITS-1:0] src_reg;
    logic [PPQN_BITS-1:0] tgt_reg;
    logic [W-1:0]         ofs_reg;
    logic [PPQN_BITS-1:0] src_eff;
    logic [PPQN_BITS-1:0] tgt_eff;
    logic                 wr;

    logic         q_valid;
    logic         q_ready;
    logic [W-1:0] q_tick;
    logic [W-1:0] q_end;
    logic         q_note;
    logic [D-1:0] q_dur;
    status_t      st;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= PPQN_DEFAULT;
            tgt_reg <= PPQN_DEFAULT;
            ofs_reg <= '0;
        end
        else if (wr)
        begin
            case (paddr[4:3])
                CFG_SRC: src_reg <= pwdata[PPQN_BITS-1:0];
                CFG_TGT: tgt_reg <= pwdata[PPQN_BITS-1:0];
                CFG_OFS: ofs_reg <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            CFG_SRC: prdata = 64'(src_reg);
            CFG_TGT: prdata = 64'(tgt_reg);
            CFG_OFS: prdata = 64'(ofs_reg);
            default: prdata = '0;
        endcase
    end

    // A rate of zero stands for the default rate.
    assign src_eff = (src_reg == '0) ? PPQN_DEFAULT : src_reg;
    assign tgt_eff = (tgt_reg == '0) ? PPQN_DEFAULT : tgt_reg;

    etr_front #(.TICK_BITS(W), .DURATION_BITS(D)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(evt.valid),
        .in_ready(evt.ready),
        .in_tick (evt.event_tick),
        .in_note (evt.is_note),
        .in_dur  (evt.note_duration),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_tick  (q_tick),
        .q_end   (q_end),
        .q_note  (q_note),
        .q_dur   (q_dur)
    );

    etr_back #(.TICK_BITS(W), .DURATION_BITS(D)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .src       (src_eff),
        .tgt       (tgt_eff),
        .ofs       (ofs_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_tick   (q_tick),
        .in_end    (q_end),
        .in_note   (q_note),
        .in_dur    (q_dur),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_tick  (res.new_tick),
        .out_dur   (res.new_duration),
        .out_status(st)
    );

    assign res.status = st;

endmodule

`default_nettype wire

### design/etr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module etr_front #(
    parameter int TICK_BITS = 64,
    parameter int DURATION_BITS = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [TICK_BITS-1:0]     in_tick,
    input  wire logic                     in_note,
    input  wire logic [DURATION_BITS-1:0] in_dur,
    output logic                          q_valid,
    input  wire logic                     q_ready,
    output logic [TICK_BITS-1:0]          q_tick,
    output logic [TICK_BITS-1:0]          q_end,
    output logic                          q_note,
    output logic [DURATION_BITS-1:0]      q_dur
);
    localparam int W = TICK_BITS;
    localparam int D = DURATION_BITS;
    localparam int EW = 2 * W + 1 + D;

    logic [EW-1:0] ent_reg [2];
    logic          wp_reg;
    logic          rp_reg;
    logic [1:0]    cnt_reg;
    logic [W:0]    end_sum;
    logic [W-1:0]  end_sat;
    logic          push;
    logic          pop;

    // The end of a note saturates at the largest tick.
    assign end_sum = {1'b0, in_tick} + (W + 1)'(in_dur);
    assign end_sat = end_sum[W] ? {W{1'b1}} : end_sum[W-1:0];

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign {q_tick, q_end, q_note, q_dur} = ent_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= {in_tick, end_sat, in_note, in_dur};
        end
    end

endmodule

`default_nettype wire

### design/etr_div.sv
`timescale 1ns / 1ps
`default_nettype none

module etr_div #(
    parameter int NB = 64,
    parameter int L = 2,
    parameter int PW = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire logic [L-1:0][NB-1:0]               dvd,
    input  wire logic [etr_pkg::PPQN_BITS-1:0]      dvs,
    input  wire logic [PW-1:0]                      pay_in,
    output logic                                    out_valid,
    output logic [L-1:0][NB-1:0]                    quo,
    output logic [L-1:0][etr_pkg::PPQN_BITS-1:0]    rem,
    output logic [PW-1:0]                           pay_out
);
    import etr_pkg::*;

    localparam int RW = PPQN_BITS;

    logic [NB-1:0]            v_reg;
    logic [L-1:0][NB-1:0]     dq_reg [NB];
    logic [L-1:0][RW-1:0]     rm_reg [NB];
    logic [PW-1:0]            py_reg [NB];

    for (genvar s = 0; s < NB; s++)
    begin : g_st
        logic                 v_prev;
        logic [L-1:0][NB-1:0] dq_prev;
        logic [L-1:0][NB-1:0] dq_next;
        logic [L-1:0][RW-1:0] rm_prev;
        logic [L-1:0][RW-1:0] rm_next;
        logic [PW-1:0]        py_prev;

        if (s == 0)
        begin : g_in
            assign v_prev  = in_valid;
            assign dq_prev = dvd;
            assign rm_prev = '0;
            assign py_prev = pay_in;
        end
        else
        begin : g_mid
            assign v_prev  = v_reg[s-1];
            assign dq_prev = dq_reg[s-1];
            assign rm_prev = rm_reg[s-1];
            assign py_prev = py_reg[s-1];
        end

        // One restoring step per stage and lane.
        always_comb
        begin
            logic [RW:0] trial;
            logic        ge;
            for (int l = 0; l < L; l++)
            begin
                trial = {rm_prev[l], dq_prev[l][NB-1]};
                ge = (trial >= {1'b0, dvs});
                rm_next[l] = ge ? RW'(trial - {1'b0, dvs}) : trial[RW-1:0];
                dq_next[l] = {dq_prev[l][NB-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dq_reg[s] <= dq_next;
                rm_reg[s] <= rm_next;
                py_reg[s] <= py_prev;
            end
        end
    end

    assign out_valid = v_reg[NB-1];
    assign quo       = dq_reg[NB-1];
    assign rem       = rm_reg[NB-1];
    assign pay_out   = py_reg[NB-1];

endmodule

`default_nettype wire

### design/etr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module etr_back #(
    parameter int TICK_BITS = 64,
    parameter int DURATION_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [etr_pkg::PPQN_BITS-1:0] src,
    input  wire logic [etr_pkg::PPQN_BITS-1:0] tgt,
    input  wire logic [TICK_BITS-1:0]          ofs,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [TICK_BITS-1:0]          in_tick,
    input  wire logic [TICK_BITS-1:0]          in_end,
    input  wire logic                          in_note,
    input  wire logic [DURATION_BITS-1:0]      in_dur,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [TICK_BITS-1:0]               out_tick,
    output logic [DURATION_BITS-1:0]           out_dur,
    output etr_pkg::status_t                   out_status
);
    import etr_pkg::*;

    localparam int W = TICK_BITS;
    localparam int D = DURATION_BITS;
    localparam int P = PPQN_BITS;
    localparam int LO = W / 2;
    localparam int HI = W - LO;
    localparam int FB = 2 * P;
    localparam int WW = W + P;
    localparam int SW = W + P + 1;
    localparam logic [W:0] DMAX = ({{W{1'b0}}, 1'b1} << D) - 1'b1;

    logic adv;

    logic [1:0][W-1:0] d1_quo;
    logic [1:0][P-1:0] d1_rem;
    logic              d1_v;
    logic              d1_note;
    logic [D-1:0]      d1_dur;

    logic                m_v_reg;
    logic [1:0][FB-1:0]  m_fp_reg;
    logic [1:0][LO+P-1:0] m_pl_reg;
    logic [1:0][HI+P-1:0] m_ph_reg;
    logic                m_note_reg;
    logic [D-1:0]        m_dur_reg;

    logic                a_v_reg;
    logic [1:0][FB-1:0]  a_fn_reg;
    logic [1:0][WW-1:0]  a_wh_reg;
    logic                a_note_reg;
    logic [D-1:0]        a_dur_reg;

    logic [1:0][FB-1:0]  d2_quo;
    logic [1:0][P-1:0]   d2_rem;
    logic                d2_v;
    logic [1:0][WW-1:0]  d2_wh;
    logic                d2_note;
    logic [D-1:0]        d2_dur;

    logic                s_v_reg;
    logic [1:0][SW-1:0]  s_sum_reg;
    logic                s_note_reg;
    logic [D-1:0]        s_dur_reg;

    logic                o_v_reg;
    logic [W-1:0]        o_tick_reg;
    logic [D-1:0]        o_dur_reg;
    status_t             o_st_reg;

    logic [W-1:0]        s_tick;
    logic [W-1:0]        s_end;
    logic [W:0]          osum;
    logic [W:0]          diff;
    logic                bad_tick;
    logic                bad_note;

    // The whole pipeline moves together; the output register is its last stage.
    assign adv      = !o_v_reg || out_ready;
    assign in_ready = adv;

    etr_div #(.NB(W), .L(2), .PW(1 + D)) u_div_whole (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (in_valid),
        .dvd      ({in_end, in_tick}),
        .dvs      (src),
        .pay_in   ({in_note, in_dur}),
        .out_valid(d1_v),
        .quo      (d1_quo),
        .rem      (d1_rem),
        .pay_out  ({d1_note, d1_dur})
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
            a_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_v_reg <= d1_v;
            a_v_reg <= m_v_reg;
            s_v_reg <= d2_v;
            o_v_reg <= s_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 2; l++)
            begin
                m_fp_reg[l] <= d1_rem[l] * tgt;
                m_pl_reg[l] <= d1_quo[l][LO-1:0] * tgt;
                m_ph_reg[l] <= d1_quo[l][W-1:LO] * tgt;
                a_fn_reg[l] <= m_fp_reg[l] + FB'(src >> 1);
                a_wh_reg[l] <= {m_ph_reg[l], {LO{1'b0}}} + WW'(m_pl_reg[l]);
                s_sum_reg[l] <= {1'b0, d2_wh[l]} + SW'(d2_quo[l]);
            end
            m_note_reg <= d1_note;
            m_dur_reg  <= d1_dur;
            a_note_reg <= m_note_reg;
            a_dur_reg  <= m_dur_reg;
            s_note_reg <= d2_note;
            s_dur_reg  <= d2_dur;
        end
    end

    etr_div #(.NB(FB), .L(2), .PW(2 * WW + 1 + D)) u_div_frac (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (a_v_reg),
        .dvd      (a_fn_reg),
        .dvs      (src),
        .pay_in   ({a_wh_reg, a_note_reg, a_dur_reg}),
        .out_valid(d2_v),
        .quo      (d2_quo),
        .rem      (d2_rem),
        .pay_out  ({d2_wh, d2_note, d2_dur})
    );

    assign s_tick   = s_sum_reg[0][W-1:0];
    assign s_end    = s_sum_reg[1][W-1:0];
    assign osum     = {1'b0, s_tick} + {1'b0, ofs};
    assign diff     = {1'b0, s_end} - {1'b0, s_tick};
    assign bad_tick = (s_sum_reg[0][SW-1:W] != '0) || osum[W];
    assign bad_note = s_note_reg && ((s_sum_reg[1][SW-1:W] != '0) || (diff > DMAX));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (bad_tick)
            begin
                o_st_reg   <= ST_TICK;
                o_tick_reg <= '0;
                o_dur_reg  <= '0;
            end
            else if (bad_note)
            begin
                o_st_reg   <= ST_NOTE;
                o_tick_reg <= '0;
                o_dur_reg  <= '0;
            end
            else
            begin
                o_st_reg   <= ST_OK;
                o_tick_reg <= osum[W-1:0];
                o_dur_reg  <= s_note_reg ? diff[D-1:0] : s_dur_reg;
            end
        end
    end

    assign out_valid  = o_v_reg;
    assign out_tick   = o_tick_reg;
    assign out_dur    = o_dur_reg;
    assign out_status = o_st_reg;

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && (o_st_reg != ST_OK) |-> (o_tick_reg == '0) && (o_dur_reg == '0))
        else $error("failed result carries nonzero fields");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && !out_ready |=> o_v_reg && $stable(o_tick_reg) && $stable(o_st_reg))
        else $error("stalled result lost or changed");

    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s_v_reg) && $stable(m_v_reg))
        else $error("pipeline moved while stalled");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        d2_v |-> (d2_quo[0][FB-1:P] == '0) && (d2_quo[1][FB-1:P] == '0))
        else $error("fraction wider than the target rate");

    a_frac_rem: assert property (@(posedge clk) disable iff (!rst_n)
        d2_v |-> (d2_rem[0] < src) && (d2_rem[1] < src))
        else $error("rounding remainder not below the source rate");

endmodule

`default_nettype wire

### tb/tb_scoreboard.sv
`timescale 1ns / 1ps

class rescale_scoreboard;
    typedef struct {
        logic [63:0] new_tick;
        logic [31:0] new_duration;
        logic [1:0]  status;
    } rescaled_t;

    rescaled_t   pending[$];
    logic [14:0] src_ppqn;
    logic [14:0] tgt_ppqn;
    logic [63:0] offset;
    int          failures;
    int          checked;
    int          status_seen[3];

    function new();
        src_ppqn = 15'd48;
        tgt_ppqn = 15'd48;
        offset = 64'd0;
        failures = 0;
        checked = 0;
    endfunction

    static function logic [64:0] scale_tick(logic [63:0] tick, logic [14:0] src,
                                            logic [14:0] tgt);
        logic [63:0]  whole;
        logic [63:0]  rem;
        logic [63:0]  frac;
        logic [127:0] prod;
        whole = tick / src;
        rem = tick % src;
        frac = (rem * tgt + src / 2) / src;
        prod = whole * tgt + frac;
        if (prod[127:64] != 0)
            return {1'b1, 64'd0};
        return {1'b0, prod[63:0]};
    endfunction

    function void note_request(logic [63:0] tick, logic is_note, logic [31:0] dur);
        rescaled_t   r;
        logic [14:0] src;
        logic [14:0] tgt;
        logic [64:0] s_tick;
        logic [64:0] s_end;
        logic [64:0] sum;
        logic [64:0] end_tick;
        logic [63:0] diff;
        src = (src_ppqn == 0) ? etr_pkg::PPQN_DEFAULT : src_ppqn;
        tgt = (tgt_ppqn == 0) ? etr_pkg::PPQN_DEFAULT : tgt_ppqn;
        r.new_tick = 0;
        r.new_duration = dur;
        r.status = etr_pkg::ST_OK;
        s_tick = scale_tick(tick, src, tgt);
        sum = {1'b0, s_tick[63:0]} + {1'b0, offset};
        if (s_tick[64] || sum[64])
            r.status = etr_pkg::ST_TICK;
        else if (is_note)
        begin
            end_tick = {1'b0, tick} + {33'd0, dur};
            if (end_tick[64])
                end_tick = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
            s_end = scale_tick(end_tick[63:0], src, tgt);
            diff = s_end[63:0] - s_tick[63:0];
            if (s_end[64] || s_end[63:0] < s_tick[63:0] || diff[63:32] != 0)
                r.status = etr_pkg::ST_NOTE;
            else
                r.new_duration = diff[31:0];
        end
        if (r.status != etr_pkg::ST_OK)
        begin
            r.new_tick = 0;
            r.new_duration = 0;
        end
        else
            r.new_tick = sum[63:0];
        pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic [63:0] tick, logic [31:0] dur, logic [1:0] st);
        rescaled_t e;
        if (pending.size() == 0)
        begin
            $error("result with no request outstanding: tick %h", tick);
            failures++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (st < 3)
            status_seen[st]++;
        if (tick !== e.new_tick)
        begin
            $error("new_tick: expected %h, got %h", e.new_tick, tick);
            failures++;
        end
        if (dur !== e.new_duration)
        begin
            $error("new_duration: expected %h, got %h", e.new_duration, dur);
            failures++;
        end
        if (st !== e.status)
        begin
            $error("status: expected %0d, got %0d", e.status, st);
            failures++;
        end
    endfunction
endclass

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import etr_pkg::*;

    localparam int LIMIT = 20000;
    localparam logic [4:0] ADDR_SRC = 5'd0;
    localparam logic [4:0] ADDR_TGT = 5'd8;
    localparam logic [4:0] ADDR_OFS = 5'd16;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          idle_cycles;
    int          sent;
    bit          stim_done;

    etr_evt_if evt ();
    etr_res_if res ();
    rescale_scoreboard board;

    event_tick_timebase_rescaler DUT (
        .clk(clk), .rst_n(rst_n), .evt(evt.sink), .res(res.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && evt.valid && evt.ready)
        begin
            board.note_request(evt.event_tick, evt.is_note, evt.note_duration);
            sent++;
        end
        if (rst_n && res.valid && res.ready)
            board.check_result(res.new_tick, res.new_duration, res.status);
        if ((evt.valid && evt.ready) || (res.valid && res.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        int wait_n;
        res.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (res.ready && res.valid)
            begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                if (wait_n > 0)
                begin
                    res.ready = 0;
                    repeat (wait_n - 1) @(negedge clk);
                end
                res.ready = 1;
            end
            else
                res.ready = 1;
        end
    end

    task automatic write_reg(logic [4:0] addr, logic [63:0] value);
        @(negedge clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = addr;
        pwdata = value;
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
        case (addr)
            ADDR_SRC: board.src_ppqn = value[14:0];
            ADDR_TGT: board.tgt_ppqn = value[14:0];
            default:  board.offset = value;
        endcase
    endtask

    task automatic configure(logic [14:0] src, logic [14:0] tgt, logic [63:0] ofs);
        write_reg(ADDR_SRC, {49'd0, src});
        write_reg(ADDR_TGT, {49'd0, tgt});
        write_reg(ADDR_OFS, ofs);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic send_event(logic [63:0] tick, logic is_note, logic [31:0] dur,
                              bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            evt.valid = 0;
            repeat (gap - 1) @(negedge clk);
        end
        evt.valid = 1;
        evt.event_tick = tick;
        evt.is_note = is_note;
        evt.note_duration = dur;
        @(posedge clk);
        while (!evt.ready) @(posedge clk);
    endtask

    task automatic end_burst();
        @(negedge clk);
        evt.valid = 0;
    endtask

    function automatic logic [63:0] rand_tick();
        logic [63:0] t;
        t = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: t = t >> $urandom_range(0, 63);
            1: t = t & 64'hFFFF;
            2: t = t & 64'hFFFF_FFFF_FFFF;
            3: t = ~(t & 64'hFF);
            default: t = t >> $urandom_range(8, 24);
        endcase
        return t;
    endfunction

    function automatic logic [31:0] rand_dur();
        logic [31:0] d;
        d = $urandom;
        if ($urandom_range(0, 2) != 0)
            d = d >> $urandom_range(0, 31);
        return d;
    endfunction

    task automatic random_phase(int count);
        bit burst;
        for (int i = 0; i < count; i++)
        begin
            burst = ($urandom_range(0, 3) == 0);
            send_event(rand_tick(), 1'($urandom_range(0, 1)), rand_dur(), burst);
        end
        end_burst();
    endtask

    initial
    begin
        logic [14:0] src_set[6];
        logic [14:0] tgt_set[6];
        logic [63:0] ofs_set[6];
        board = new();
        sent = 0;
        idle_cycles = 0;
        stim_done = 0;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        evt.valid = 0;
        evt.event_tick = 0;
        evt.is_note = 0;
        evt.note_duration = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_event(64'd0, 0, 32'd0, 0);
        send_event(64'd100, 1, 32'd24, 0);
        send_event(64'hFFFF_FFFF_FFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
        send_event(64'hFFFF_FFFF_FFFF_FFFF, 1, 32'hFFFF_FFFF, 0);
        send_event(64'hFFFF_FFFF_FFFF_FF00, 1, 32'hFFFF_FFFF, 0);
        end_burst();
        drain();
        configure(15'd0, 15'd0, 64'd0);
        send_event(64'd47, 1, 32'd49, 0);
        send_event(64'd96, 0, 32'h1234_5678, 0);
        end_burst();
        drain();
        configure(15'd1, 15'd32767, 64'hFFFF_FFFF_FFFF_FFF0);
        send_event(64'd0, 0, 32'd0, 0);
        send_event(64'd1, 0, 32'd0, 0);
        send_event(64'd0, 1, 32'd1, 0);
        send_event(64'd0, 1, 32'd200000, 0);
        send_event(64'h0000_4000_0000_0000, 0, 32'd5, 0);
        end_burst();
        drain();
        configure(15'd32767, 15'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_event(64'd0, 1, 32'd16383, 0);
        send_event(64'd0, 1, 32'd16384, 0);
        send_event(64'd1, 0, 32'd0, 0);
        send_event(64'hFFFF_FFFF_FFFF_FFFF, 1, 32'hFFFF_FFFF, 0);
        end_burst();
        drain();
        configure(15'd3, 15'd2, 64'd1000);
        send_event(64'hFFFF_FFFF_FFFF_FFFF, 1, 32'd10, 0);
        send_event(64'd1, 1, 32'd1, 0);
        send_event(64'd5, 1, 32'hFFFF_FFFF, 0);
        end_burst();
        drain();

        src_set = '{15'd48, 15'd96, 15'd0, 15'd480, 15'd7, 15'd32767};
        tgt_set = '{15'd480, 15'd48, 15'd960, 15'd0, 15'd32767, 15'd1};
        ofs_set = '{64'd0, 64'd12345, 64'hFFFF_FFFF_0000_0000, 64'd0,
                    64'hFFFF_FFFF_FFFF_FFFF, 64'd99};
        for (int p = 0; p < 6; p++)
        begin
            configure(src_set[p], tgt_set[p], ofs_set[p]);
            random_phase(150);
            drain();
            configure(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                      ($urandom_range(0, 1) != 0) ? 64'd0 : {$urandom, $urandom});
            random_phase(150);
            drain();
        end

        while (board.pending.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
        $display("Sent %0d events through %0d rate settings, %0d results checked.",
                 sent, 17, board.checked);
        $display("Status counts: ok %0d, tick overflow %0d, note failure %0d.",
                 board.status_seen[0], board.status_seen[1], board.status_seen[2]);
        if (board.failures == 0 && board.pending.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
